FILE: hw/rtl/chot_pkg.sv
// package for the chained hash object table
// holds sizes, opcode and status codes, and the node payload type; no dependencies
package chot_pkg;

  localparam int Buckets = 256;
  localparam int Nodes = 1024;
  localparam int BucketW = (Buckets > 1) ? $clog2(Buckets) : 1;
  localparam int NodeW = $clog2(Nodes);
  localparam int PtrW = $clog2(Nodes + 1);
  localparam logic [PtrW-1:0] Nil = PtrW'(Nodes);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic [63:0] key;
    logic [30:0] size;
    logic [15:0] thread;
    logic [30:0] trace;
  } node_data_t;

endpackage

FILE: hw/rtl/chot_link_mem.sv
// node link memory, written by the top level's free-list rebuild sweep
// one write port, one registered read port; uses chot_pkg
module chot_link_mem (
  input  logic                        clk,
  input  logic                        we,
  input  logic [chot_pkg::NodeW-1:0]  waddr,
  input  logic [chot_pkg::PtrW-1:0]   wdata,
  input  logic [chot_pkg::NodeW-1:0]  raddr,
  output logic [chot_pkg::PtrW-1:0]   rdata
);

  logic [chot_pkg::PtrW-1:0] mem [chot_pkg::Nodes];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/chained_hash_object_table_top.sv
// top level of the chained hash object table
// bucket head, node data and node link memories plus the walk sequencer; uses chot_pkg
//
// channel  direction  handshake            fields
// command  in         start & !busy        opcode obj_id obj_size thread_num trace_num
// result   out        done (one cycle)     status found_size found_thread found_trace
//
// add: links a free node in at the head of its chain; ST_FULL when the pool is empty.
// lookup: walks the chain from the bucket head to the match; remove adds an unlink step.
// a miss ends at the chain end. each node costs a link/key read of the node memories.
// clear and reset: a sweep rebuilding all bucket heads and the free list,
// busy stays high during it; clear's result comes at its end.
// results cannot be stalled; busy is high from acceptance until done.
module chained_hash_object_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [63:0] obj_id,
  input  logic [30:0] obj_size,
  input  logic [15:0] thread_num,
  input  logic [30:0] trace_num,
  output logic        done,
  output logic [1:0]  status,
  output logic [30:0] found_size,
  output logic [15:0] found_thread,
  output logic [30:0] found_trace
);

  localparam int SweepN = (chot_pkg::Buckets > chot_pkg::Nodes) ? chot_pkg::Buckets
                                                                 : chot_pkg::Nodes;
  localparam int SweepW = $clog2(SweepN + 1);

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_HEAD_RD, S_HEAD_WAIT, S_FREE_WAIT, S_NODE_RD, S_NODE_WAIT,
    S_UNLINK, S_DONE
  } state_t;

  state_t state;

  // memories
  logic [chot_pkg::PtrW-1:0] head_mem [chot_pkg::Buckets];
  logic [chot_pkg::PtrW-1:0] head_q;
  chot_pkg::node_data_t      data_mem [chot_pkg::Nodes];
  chot_pkg::node_data_t      data_q;

  logic                        head_we;
  logic [chot_pkg::BucketW-1:0] head_waddr;
  logic [chot_pkg::PtrW-1:0]   head_wdata;
  logic                        data_we;

  logic                        link_we;
  logic [chot_pkg::NodeW-1:0]  link_waddr, link_raddr;
  logic [chot_pkg::PtrW-1:0]   link_wdata, link_q;

  // registered command and walk state
  chot_pkg::opcode_t           op;
  logic [63:0]                 id;
  logic [30:0]                 sz;
  logic [15:0]                 thr;
  logic [30:0]                 trc;
  logic [chot_pkg::BucketW-1:0] bkt;
  logic [chot_pkg::PtrW-1:0]   free_head;
  logic [chot_pkg::PtrW-1:0]   cur, prev;
  logic [SweepW-1:0]           sweep_cnt;
  logic [SweepW:0]             steps;
  logic                        clear_cmd;

  logic [chot_pkg::BucketW-1:0] in_bkt;
  assign in_bkt = chot_pkg::BucketW'(obj_id % 64'(chot_pkg::Buckets));

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_q <= head_mem[bkt];
  end

  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[free_head[chot_pkg::NodeW-1:0]] <= '{key: id, size: sz, thread: thr,
                                                      trace: trc};
    end
    data_q <= data_mem[cur[chot_pkg::NodeW-1:0]];
  end

  chot_link_mem u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_q)
  );

  // write port steering
  always_comb begin
    head_we    = 1'b0;
    head_waddr = bkt;
    head_wdata = chot_pkg::Nil;
    data_we    = 1'b0;
    link_we    = 1'b0;
    link_waddr = cur[chot_pkg::NodeW-1:0];
    link_wdata = free_head;
    link_raddr = cur[chot_pkg::NodeW-1:0];
    unique case (state)
      S_SWEEP: begin
        head_we    = (sweep_cnt < SweepW'(chot_pkg::Buckets));
        head_waddr = chot_pkg::BucketW'(sweep_cnt);
        link_we    = (sweep_cnt < SweepW'(chot_pkg::Nodes));
        link_waddr = chot_pkg::NodeW'(sweep_cnt);
        link_wdata = chot_pkg::PtrW'(sweep_cnt) + chot_pkg::PtrW'(1);
      end
      // keep the free head's link on the read port until the add uses it
      S_HEAD_RD, S_HEAD_WAIT: link_raddr = free_head[chot_pkg::NodeW-1:0];
      S_FREE_WAIT: begin
        // new node goes to the head of its chain
        head_we    = 1'b1;
        head_wdata = free_head;
        data_we    = 1'b1;
        link_we    = 1'b1;
        link_waddr = free_head[chot_pkg::NodeW-1:0];
        link_wdata = head_q;
      end
      S_UNLINK: begin
        // unlink cur, link_q holds its successor
        head_we    = (prev == chot_pkg::Nil);
        head_wdata = link_q;
        link_we    = (prev != chot_pkg::Nil);
        link_waddr = prev[chot_pkg::NodeW-1:0];
        link_wdata = link_q;
      end
      S_DONE: begin
        if (op == chot_pkg::OP_REMOVE && status == chot_pkg::ST_OK && !clear_cmd) begin
          link_we    = 1'b1;
          link_waddr = cur[chot_pkg::NodeW-1:0];
          link_wdata = free_head;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_SWEEP;
      sweep_cnt    <= '0;
      free_head    <= '0;
      done         <= 1'b0;
      clear_cmd    <= 1'b0;
      status       <= chot_pkg::ST_OK;
      found_size   <= '0;
      found_thread <= '0;
      found_trace  <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_SWEEP: begin
          if (sweep_cnt == SweepW'(SweepN - 1)) begin
            free_head <= '0;
            sweep_cnt <= '0;
            if (clear_cmd) begin
              clear_cmd    <= 1'b0;
              done         <= 1'b1;
              status       <= chot_pkg::ST_OK;
              found_size   <= '0;
              found_thread <= '0;
              found_trace  <= '0;
            end
            state <= S_IDLE;
          end else begin
            sweep_cnt <= sweep_cnt + SweepW'(1);
          end
        end
        S_IDLE: begin
          if (start) begin
            op    <= chot_pkg::opcode_t'(opcode);
            id    <= obj_id;
            sz    <= obj_size;
            thr   <= thread_num;
            trc   <= trace_num;
            bkt   <= in_bkt;
            prev  <= chot_pkg::Nil;
            steps <= '0;
            status       <= chot_pkg::ST_OK;
            found_size   <= '0;
            found_thread <= '0;
            found_trace  <= '0;
            if (chot_pkg::opcode_t'(opcode) == chot_pkg::OP_CLEAR) begin
              clear_cmd <= 1'b1;
              sweep_cnt <= '0;
              state     <= S_SWEEP;
            end else begin
              state <= S_HEAD_RD;
            end
          end
        end
        S_HEAD_RD: state <= S_HEAD_WAIT;  // head_q for bkt valid next cycle
        S_HEAD_WAIT: begin
          if (op == chot_pkg::OP_ADD) begin
            if (free_head == chot_pkg::Nil) begin
              status <= chot_pkg::ST_FULL;
              state  <= S_DONE;
            end else begin
              state <= S_FREE_WAIT;
            end
          end else begin
            cur   <= head_q;
            state <= (head_q == chot_pkg::Nil) ? S_DONE : S_NODE_RD;
            if (head_q == chot_pkg::Nil) status <= chot_pkg::ST_NOT_FOUND;
          end
        end
        S_FREE_WAIT: begin
          free_head <= link_q;  // link of the old free head
          state     <= S_DONE;
        end
        S_NODE_RD: state <= S_NODE_WAIT;
        S_NODE_WAIT: begin
          if (data_q.key == id) begin
            if (op == chot_pkg::OP_LOOKUP) begin
              found_size   <= data_q.size;
              found_thread <= data_q.thread;
              found_trace  <= data_q.trace;
              state        <= S_DONE;
            end else begin
              state <= S_UNLINK;
            end
          end else if (link_q == chot_pkg::Nil ||
                       steps == (SweepW + 1)'(chot_pkg::Nodes - 1)) begin
            status <= chot_pkg::ST_NOT_FOUND;
            state  <= S_DONE;
          end else begin
            prev  <= cur;
            cur   <= link_q;
            steps <= steps + (SweepW + 1)'(1);
            state <= S_NODE_RD;
          end
        end
        S_UNLINK: state <= S_DONE;
        S_DONE: begin
          if (op == chot_pkg::OP_REMOVE && status == chot_pkg::ST_OK) begin
            free_head <= cur;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // assertions
  a_done_not_busy_start: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while busy");
  a_start_leads_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted command did not raise busy");
  a_found_zero_miss: assert property (@(posedge clk) disable iff (rst)
    (done && status != chot_pkg::ST_OK) |-> (found_size == '0 && found_trace == '0))
    else $error("found fields set on a miss");
  a_full_only_when_empty: assert property (@(posedge clk) disable iff (rst)
    (done && status == chot_pkg::ST_FULL) |-> (free_head == chot_pkg::Nil))
    else $error("pool full reported with free nodes");

endmodule
